// ----- rtl/core/rpfh_pkg.sv -----
// Shared types and constants for the ray/polyline nearest-hit block.
// Used by the top level, the sequencer and the datapath; has no dependencies of its own.
package rpfh_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int T_FRAC = 24;
  localparam int S_FRAC = 32;
  localparam int T_W = 48;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_NORM, S_TEST, S_DIVT, S_CMP, S_DIVS, S_LERP, S_UPD, S_FIN
  } state_e;

  // Product selection for the shared multiplier.
  typedef enum logic [2:0] {
    OP_DXEY, OP_DYEX, OP_WXEY, OP_WYEX, OP_WXDY, OP_WYDX, OP_EXS, OP_EYS
  } op_e;

  typedef struct packed {
    logic load_in;
    logic mul_en;
    op_e  mul_op;
    logic acc_en;
    op_e  acc_op;
    logic norm;
    logic div_start;
    logic div_sel_s;
    logic take_t;
    logic upd_best;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic have_prev;
    logic last;
    logic den_zero;
    logic hit_range;
    logic better;
    logic div_busy;
    logic out_busy;
  } sts_t;

endpackage

// ----- rtl/core/ray_polyline_first_hit.sv -----
// Top level of the ray/polyline nearest-hit block: configuration registers
// on an APB-style port, sequencer and datapath. Depends on rpfh_pkg.
//
// Usage: write origin_x, origin_y, dir_x, dir_y (byte addresses 0, 4, 8, 12;
// 0, 8, 16, 24 when COORD_BITS exceeds 32) while the block is idle. Stream
// polyline vertices on the input channel; each vertex after the first closes
// a segment. On the vertex flagged last_vertex one result transfer follows:
// found and the kept hit point, both coordinates zero when nothing was hit.
// When a vertex's segment is hit and improves the kept hit, the shared
// multiplier forms the cross products and the hit point, and the
// one-bit-per-cycle divider runs twice, for the line and segment parameters.
// A missed segment takes one division or none; a first vertex is only stored.
// Reset restores the register defaults (direction +x) and clears the polyline
// state. When the receiver stalls, the result waits in the output register;
// the next polyline is accepted meanwhile and only its own last vertex waits
// for the slot to free.
module ray_polyline_first_hit #(
  parameter int COORD_BITS = rpfh_pkg::COORD_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [((COORD_BITS > 32) ? 5 : 4)-1:0] paddr,
  input  logic [((COORD_BITS > 32) ? 64 : 32)-1:0] pwdata,
  output logic [((COORD_BITS > 32) ? 64 : 32)-1:0] prdata,
  output logic                                  pready,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [COORD_BITS-1:0]          vertex_x_i,
  input  logic signed [COORD_BITS-1:0]          vertex_y_i,
  input  logic                                  last_vertex_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic                                  found_o,
  output logic signed [COORD_BITS-1:0]          hit_x_o,
  output logic signed [COORD_BITS-1:0]          hit_y_o
);
  import rpfh_pkg::*;

  localparam int AW = (COORD_BITS > 32) ? 5 : 4;
  localparam int DW = (COORD_BITS > 32) ? 64 : 32;

  typedef enum logic [1:0] {REG_ORIGIN_X, REG_ORIGIN_Y, REG_DIR_X, REG_DIR_Y} reg_e;

  logic signed [COORD_BITS-1:0] ox_q, oy_q, dx_q, dy_q;
  reg_e  idx;
  logic  wr;
  cmd_t  cmd;
  sts_t  sts;

  assign idx    = reg_e'(paddr[AW-1:AW-2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ox_q <= '0;
      oy_q <= '0;
      dx_q <= COORD_BITS'(65536);
      dy_q <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_ORIGIN_X: ox_q <= pwdata[COORD_BITS-1:0];
        REG_ORIGIN_Y: oy_q <= pwdata[COORD_BITS-1:0];
        REG_DIR_X:    dx_q <= pwdata[COORD_BITS-1:0];
        REG_DIR_Y:    dy_q <= pwdata[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ORIGIN_X: prdata = DW'(unsigned'(ox_q));
      REG_ORIGIN_Y: prdata = DW'(unsigned'(oy_q));
      REG_DIR_X:    prdata = DW'(unsigned'(dx_q));
      REG_DIR_Y:    prdata = DW'(unsigned'(dy_q));
      default:      prdata = '0;
    endcase
  end

  rpfh_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  rpfh_dp #(.COORD_BITS(COORD_BITS)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .origin_x_i   (ox_q),
    .origin_y_i   (oy_q),
    .dir_x_i      (dx_q),
    .dir_y_i      (dy_q),
    .vertex_x_i   (vertex_x_i),
    .vertex_y_i   (vertex_y_i),
    .last_vertex_i(last_vertex_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .found_o      (found_o),
    .hit_x_o      (hit_x_o),
    .hit_y_o      (hit_y_o)
  );
endmodule

// ----- rtl/core/rpfh_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing beyond its parameters.
module rpfh_div #(
  parameter int NUM_W = 98,
  parameter int DEN_W = 67
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic [NUM_W-1:0] quo_o
);
  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_q, num_d, quo_q, quo_d;
  logic [DEN_W:0]   rem_q, rem_d, rem_sh;
  logic [DEN_W-1:0] den_q, den_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             busy_q, busy_d;

  always_comb begin
    num_d  = num_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    rem_sh = {rem_q[DEN_W-1:0], num_q[NUM_W-1]};
    if (start_i) begin
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      quo_d  = '0;
      cnt_d  = CW'(NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[NUM_W-2:0], 1'b0};
      if (rem_sh >= {1'b0, den_q}) begin
        rem_d = rem_sh - {1'b0, den_q};
        quo_d = {quo_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[NUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;
endmodule

// ----- rtl/core/rpfh_ctrl.sv -----
// Sequencer for the nearest-hit block: steps the datapath through one segment.
// Depends on rpfh_pkg for the state, command and status types.
module rpfh_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rpfh_pkg::sts_t sts_i,
  output rpfh_pkg::cmd_t cmd_o
);
  import rpfh_pkg::*;

  state_e     state_q, state_d;
  logic [2:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        cnt_d = '0;
        if (in_valid_i) state_d = S_MUL;
      end
      S_MUL: begin
        cnt_d = cnt_q + 3'd1;
        if (!sts_i.have_prev) state_d = S_FIN;
        else if (cnt_q == 3'd6) state_d = S_NORM;
      end
      S_NORM: state_d = S_TEST;
      S_TEST: begin
        if (sts_i.den_zero || !sts_i.hit_range) state_d = S_FIN;
        else state_d = S_DIVT;
      end
      S_DIVT: if (!sts_i.div_busy) state_d = S_CMP;
      S_CMP: begin
        if (sts_i.better) state_d = S_DIVS;
        else state_d = S_FIN;
      end
      S_DIVS: begin
        cnt_d = '0;
        if (!sts_i.div_busy) state_d = S_LERP;
      end
      S_LERP: begin
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd2) state_d = S_UPD;
      end
      S_UPD: state_d = S_FIN;
      S_FIN: if (!(sts_i.last && sts_i.out_busy)) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      S_MUL: begin
        cmd_o.mul_en = sts_i.have_prev && (cnt_q < 3'd6);
        cmd_o.mul_op = op_e'(cnt_q);
        cmd_o.acc_en = sts_i.have_prev && (cnt_q != 3'd0);
        cmd_o.acc_op = op_e'(cnt_q - 3'd1);
      end
      S_NORM: cmd_o.norm = 1'b1;
      S_TEST: cmd_o.div_start = !(sts_i.den_zero || !sts_i.hit_range);
      S_CMP: begin
        cmd_o.take_t    = 1'b1;
        cmd_o.div_start = sts_i.better;
        cmd_o.div_sel_s = 1'b1;
      end
      S_LERP: begin
        cmd_o.mul_en = cnt_q < 3'd2;
        cmd_o.mul_op = op_e'(cnt_q + 3'd6);
        cmd_o.acc_en = cnt_q != 3'd0;
        cmd_o.acc_op = op_e'(cnt_q + 3'd5);
      end
      S_UPD: cmd_o.upd_best = 1'b1;
      S_FIN: cmd_o.finish = !(sts_i.last && sts_i.out_busy);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end
endmodule

// ----- rtl/core/rpfh_dp.sv -----
// Datapath: vertex and hit registers, shared multiplier, cross products,
// divider and output register. Depends on rpfh_pkg and rpfh_div.
module rpfh_dp #(
  parameter int COORD_BITS = rpfh_pkg::COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rpfh_pkg::cmd_t               cmd_i,
  output rpfh_pkg::sts_t               sts_o,
  input  logic signed [COORD_BITS-1:0] origin_x_i,
  input  logic signed [COORD_BITS-1:0] origin_y_i,
  input  logic signed [COORD_BITS-1:0] dir_x_i,
  input  logic signed [COORD_BITS-1:0] dir_y_i,
  input  logic signed [COORD_BITS-1:0] vertex_x_i,
  input  logic signed [COORD_BITS-1:0] vertex_y_i,
  input  logic                         last_vertex_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         found_o,
  output logic signed [COORD_BITS-1:0] hit_x_o,
  output logic signed [COORD_BITS-1:0] hit_y_o
);
  import rpfh_pkg::*;

  localparam int C     = COORD_BITS;
  localparam int MW    = (C + 1 > S_FRAC + 2) ? C + 1 : S_FRAC + 2;
  localparam int XW    = 2 * C + 3;
  localparam int NUM_W = 2 * C + S_FRAC + 2;

  logic signed [C-1:0]    vx_q, vy_q, px_q, py_q, bx_q, by_q, hx_q, hy_q;
  logic signed [C-1:0]    ox_q, oy_q;
  logic                   last_q, have_prev_q, hit_seen_q, ntneg_q;
  logic signed [C:0]      ex, ey, wx, wy;
  logic signed [MW-1:0]   ma, mb, s_op;
  logic signed [2*MW-1:0] p_q, lsum;
  logic signed [XW-1:0]   den_q, nt_q, ns_q, acc_p, nt_mag;
  logic signed [T_W-1:0]  t_q, best_q, tsat;
  logic [NUM_W-1:0]       div_num, quo;
  logic                   div_busy, better;
  logic                   out_valid_q, found_q;
  logic signed [C-1:0]    ox_r, oy_r;

  assign ex = (C+1)'(vx_q) - (C+1)'(px_q);
  assign ey = (C+1)'(vy_q) - (C+1)'(py_q);
  assign wx = (C+1)'(px_q) - (C+1)'(origin_x_i);
  assign wy = (C+1)'(py_q) - (C+1)'(origin_y_i);
  assign s_op = MW'($signed({1'b0, quo[S_FRAC:0]}));

  always_comb begin
    unique case (cmd_i.mul_op)
      OP_DXEY: begin ma = MW'(dir_x_i); mb = MW'(ey); end
      OP_DYEX: begin ma = MW'(dir_y_i); mb = MW'(ex); end
      OP_WXEY: begin ma = MW'(wx); mb = MW'(ey); end
      OP_WYEX: begin ma = MW'(wy); mb = MW'(ex); end
      OP_WXDY: begin ma = MW'(wx); mb = MW'(dir_y_i); end
      OP_WYDX: begin ma = MW'(wy); mb = MW'(dir_x_i); end
      OP_EXS:  begin ma = MW'(ex); mb = s_op; end
      OP_EYS:  begin ma = MW'(ey); mb = s_op; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  assign acc_p  = XW'(p_q);
  assign lsum   = p_q + (2*MW)'(64'd1 << (S_FRAC - 1));
  assign nt_mag = ntneg_q ? -nt_q : nt_q;
  assign div_num = cmd_i.div_sel_s ? (NUM_W'(ns_q) << S_FRAC)
                                   : (NUM_W'(nt_mag) << T_FRAC);

  // Saturate the quotient to the signed 48-bit line parameter.
  always_comb begin
    if (ntneg_q) begin
      if (quo > NUM_W'(64'd1 << (T_W - 1))) tsat = {1'b1, {(T_W-1){1'b0}}};
      else tsat = -$signed(quo[T_W-1:0]);
    end else begin
      if (quo > NUM_W'((64'd1 << (T_W - 1)) - 64'd1)) tsat = {1'b0, {(T_W-1){1'b1}}};
      else tsat = $signed(quo[T_W-1:0]);
    end
  end
  assign better = !hit_seen_q || (tsat < best_q);

  rpfh_div #(.NUM_W(NUM_W), .DEN_W(XW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (div_num),
    .den_i  (den_q),
    .busy_o (div_busy),
    .quo_o  (quo)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      vx_q   <= vertex_x_i;
      vy_q   <= vertex_y_i;
      den_q  <= '0;
      nt_q   <= '0;
      ns_q   <= '0;
    end
    if (cmd_i.mul_en) p_q <= ma * mb;
    if (cmd_i.acc_en) begin
      unique case (cmd_i.acc_op)
        OP_DXEY: den_q <= den_q + acc_p;
        OP_DYEX: den_q <= den_q - acc_p;
        OP_WXEY: nt_q  <= nt_q + acc_p;
        OP_WYEX: nt_q  <= nt_q - acc_p;
        OP_WXDY: ns_q  <= ns_q + acc_p;
        OP_WYDX: ns_q  <= ns_q - acc_p;
        OP_EXS:  hx_q  <= px_q + lsum[C+S_FRAC-1:S_FRAC];
        OP_EYS:  hy_q  <= py_q + lsum[C+S_FRAC-1:S_FRAC];
        default: ;
      endcase
    end
    if (cmd_i.norm) begin
      if (den_q < 0) begin
        den_q   <= -den_q;
        nt_q    <= -nt_q;
        ns_q    <= -ns_q;
        ntneg_q <= (-nt_q) < 0;
      end else begin
        ntneg_q <= nt_q < 0;
      end
    end
    if (cmd_i.take_t) t_q <= tsat;
    if (out_valid_o == 1'b0 || out_ready_i) begin
      // Output payload only moves when the slot is free.
      if (cmd_i.finish && last_q) begin
        bx_q <= hit_seen_q ? ox_r : '0;
        by_q <= hit_seen_q ? oy_r : '0;
      end
    end
  end

  assign ox_r = ox_q;
  assign oy_r = oy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q        <= '0;
      py_q        <= '0;
      ox_q        <= '0;
      oy_q        <= '0;
      best_q      <= '0;
      have_prev_q <= 1'b0;
      hit_seen_q  <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      if (cmd_i.load_in) last_q <= last_vertex_i;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (cmd_i.upd_best) begin
        best_q     <= t_q;
        ox_q       <= hx_q;
        oy_q       <= hy_q;
        hit_seen_q <= 1'b1;
      end
      if (cmd_i.finish) begin
        px_q        <= vx_q;
        py_q        <= vy_q;
        have_prev_q <= !last_q;
        if (last_q) begin
          out_valid_q <= 1'b1;
          found_q     <= hit_seen_q;
          hit_seen_q  <= 1'b0;
          best_q      <= '0;
          ox_q        <= '0;
          oy_q        <= '0;
          px_q        <= '0;
          py_q        <= '0;
        end
      end
    end
  end

  assign sts_o.have_prev = have_prev_q;
  assign sts_o.last      = last_q;
  assign sts_o.den_zero  = den_q == '0;
  assign sts_o.hit_range = (ns_q >= 0) && (ns_q <= den_q);
  assign sts_o.better    = better;
  assign sts_o.div_busy  = div_busy;
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign hit_x_o     = bx_q;
  assign hit_y_o     = by_q;
endmodule

// ----- rtl/core/rpfh_checker.sv -----
// Port-level checks for ray_polyline_first_hit, attached by bind.
// Depends only on the top level's ports.
module rpfh_checker #(
  parameter int COORD_BITS = 32
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic                  found_o,
  input logic [COORD_BITS-1:0] hit_x_o,
  input logic [COORD_BITS-1:0] hit_y_o
);
  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(hit_x_o) && $stable(hit_y_o)
      && $stable(found_o))
    else $error("result changed while stalled");

  // A miss reports a zero point.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> hit_x_o == '0 && hit_y_o == '0)
    else $error("miss with nonzero point");

  // One vertex at a time: an accepted transfer drops ready next cycle.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second vertex taken while busy");
endmodule

bind ray_polyline_first_hit rpfh_checker #(.COORD_BITS(COORD_BITS)) u_rpfh_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .found_o    (found_o),
  .hit_x_o    (hit_x_o),
  .hit_y_o    (hit_y_o)
);

// ----- bench/tb_ray_polyline_first_hit.sv -----
// Self-checking testbench for ray_polyline_first_hit: directed table, then random polylines.
// A built-in nearest-crossing predictor checks every result. Depends on rpfh_pkg and the block.
module tb_ray_polyline_first_hit;
  import rpfh_pkg::*;

  localparam int CW = COORD_BITS_DEF;

  // Register byte addresses.
  localparam logic [3:0] ADDR_ORIGIN_X = 4'd0;
  localparam logic [3:0] ADDR_ORIGIN_Y = 4'd4;
  localparam logic [3:0] ADDR_DIR_X    = 4'd8;
  localparam logic [3:0] ADDR_DIR_Y    = 4'd12;

  localparam logic signed [CW-1:0] CMAX = 32'sh7fffffff;
  localparam logic signed [CW-1:0] CMIN = 32'sh80000000;
  localparam logic signed [CW-1:0] ONE  = 32'sd65536;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [CW-1:0] vertex_x_i = '0, vertex_y_i = '0;
  logic last_vertex_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic found_o;
  logic signed [CW-1:0] hit_x_o, hit_y_o;

  ray_polyline_first_hit u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  typedef struct packed {
    logic                 found;
    logic signed [CW-1:0] hx;
    logic signed [CW-1:0] hy;
  } hit_t;

  hit_t hit_q[$];
  int   err_cnt = 0;
  bit   calm = 1'b0;
  bit   hold_req = 1'b0;
  int   hold_cnt = 0;
  int   sent = 0;

  // Predictor copy of the line registers and the polyline state.
  logic signed [63:0] ln_ox, ln_oy, ln_dx, ln_dy;
  logic signed [63:0] pv_x, pv_y, kept_t, kept_x, kept_y;
  bit pv_valid, kept_valid;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  function automatic logic signed [159:0] xprod(input logic signed [159:0] ax,
      input logic signed [159:0] ay, input logic signed [159:0] bx, input logic signed [159:0] by);
    return ax * by - ay * bx;
  endfunction

  function automatic void poly_clear();
    pv_x = 0; pv_y = 0; pv_valid = 0; kept_valid = 0; kept_t = 0; kept_x = 0; kept_y = 0;
  endfunction

  function automatic void trace_segment(input logic signed [63:0] px, input logic signed [63:0] py,
                                        input logic signed [63:0] qx, input logic signed [63:0] qy);
    logic signed [159:0] ex, ey, wx, wy, den, nt, ns, q, tv, s, cap;
    ex = qx - px; ey = qy - py;
    wx = px - ln_ox; wy = py - ln_oy;
    den = xprod(ln_dx, ln_dy, ex, ey);
    nt  = xprod(wx, wy, ex, ey);
    ns  = xprod(wx, wy, ln_dx, ln_dy);
    if (den == 0) return;
    if (den < 0) begin
      den = -den; nt = -nt; ns = -ns;
    end
    if (ns < 0 || ns > den) return;
    cap = 160'sd1 <<< 47;
    if (nt < 0) begin
      q = ((-nt) <<< T_FRAC) / den;
      if (q > cap) q = cap;
      tv = -q;
    end else begin
      q = (nt <<< T_FRAC) / den;
      if (q > cap - 1) q = cap - 1;
      tv = q;
    end
    if (kept_valid && !(tv < kept_t)) return;
    s = (ns <<< S_FRAC) / den;
    kept_t = tv;
    kept_x = px + 64'((ex * s + (160'sd1 <<< 31)) >>> 32);
    kept_y = py + 64'((ey * s + (160'sd1 <<< 31)) >>> 32);
    kept_valid = 1;
  endfunction

  // Advances the predictor by one vertex; returns 1 when a result is due.
  function automatic bit vertex_step(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                                     input logic last, output hit_t res);
    logic signed [63:0] vx, vy;
    vx = x; vy = y;
    if (pv_valid) trace_segment(pv_x, pv_y, vx, vy);
    pv_x = vx; pv_y = vy; pv_valid = 1;
    res = '0;
    if (!last) return 0;
    if (kept_valid) res = '{1'b1, kept_x[CW-1:0], kept_y[CW-1:0]};
    poly_clear();
    return 1;
  endfunction

  task automatic reg_write(input logic [3:0] addr, input logic signed [CW-1:0] val);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= addr; pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (addr)
      ADDR_ORIGIN_X: ln_ox = val;
      ADDR_ORIGIN_Y: ln_oy = val;
      ADDR_DIR_X:    ln_dx = val;
      default:       ln_dy = val;
    endcase
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b0; penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== val) report("register readback", prdata, val);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0;
  endtask

  task automatic set_line(input logic signed [CW-1:0] ox, input logic signed [CW-1:0] oy,
                          input logic signed [CW-1:0] dx, input logic signed [CW-1:0] dy);
    reg_write(ADDR_ORIGIN_X, ox);
    reg_write(ADDR_ORIGIN_Y, oy);
    reg_write(ADDR_DIR_X, dx);
    reg_write(ADDR_DIR_Y, dy);
  endtask

  // Offers one vertex and predicts at the transfer. A typed result overrides the prediction.
  task automatic send_vertex(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                             input logic last, input bit typed, input hit_t want);
    hit_t res;
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 34) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    vertex_x_i <= x; vertex_y_i <= y; last_vertex_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent++;
    if (vertex_step(x, y, last, res)) hit_q.push_back(typed ? want : res);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (hit_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  function automatic logic signed [CW-1:0] rand_coord(input logic signed [CW-1:0] base, input bit near);
    if (near) return base + $signed(CW'($urandom_range(8 * 65536))) - 4 * 65536;
    return $urandom;
  endfunction

  task automatic random_polylines(input int count, input bit near_only);
    int n;
    bit near;
    while (count > 0) begin
      n = $urandom_range(8, 1);
      near = near_only || ($urandom_range(99) < 70);
      for (int k = 0; k < n; k++) begin
        // A few stray last flags break polylines into odd pieces.
        send_vertex(rand_coord(ln_ox[CW-1:0], near), rand_coord(ln_oy[CW-1:0], near),
                    (k == n - 1) || ($urandom_range(99) < 3), 1'b0, '0);
        count--;
      end
    end
  endtask

  typedef struct {
    logic signed [CW-1:0] x, y;
    logic last;
    bit   typed;
    hit_t want;
  } row_t;

  // Default line: through the origin along +x.
  row_t dir_rows[] = '{
    '{ONE, ONE, 1'b1, 1'b1, '{1'b0, 0, 0}},                  // single vertex, no segment
    '{0, -ONE, 1'b0, 1'b0, '0},
    '{0, ONE, 1'b1, 1'b1, '{1'b1, 0, 0}},                    // vertical crossing at origin
    '{-ONE, ONE, 1'b0, 1'b0, '0},
    '{ONE, ONE, 1'b1, 1'b1, '{1'b0, 0, 0}},                  // parallel segment skipped
    '{CMAX, CMAX, 1'b0, 1'b0, '0},
    '{CMIN, CMIN, 1'b0, 1'b0, '0},
    '{CMAX, CMIN, 1'b0, 1'b0, '0},
    '{CMIN, CMAX, 1'b1, 1'b0, '0},                           // extremes
    '{3 * ONE, -ONE, 1'b0, 1'b0, '0},
    '{3 * ONE, ONE, 1'b0, 1'b0, '0},
    '{-2 * ONE, -ONE, 1'b0, 1'b0, '0},
    '{-2 * ONE, ONE, 1'b0, 1'b0, '0},
    '{3 * ONE, ONE, 1'b1, 1'b0, '0},                         // each smaller t replaces the kept hit
    '{ONE, 0, 1'b0, 1'b0, '0},
    '{ONE, 2 * ONE, 1'b1, 1'b0, '0},                         // hit at segment end point
    '{CMIN, 0, 1'b0, 1'b0, '0},
    '{CMIN, ONE, 1'b0, 1'b0, '0},
    '{CMAX, -ONE, 1'b1, 1'b0, '0}                            // far hit at x = CMIN is kept
  };

  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_cnt = 3000;
      hold_req = 1'b0;
    end
    if (!rst_ni) out_ready_i <= 1'b0;
    else if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready_i <= 1'b0;
    end else out_ready_i <= calm || ($urandom_range(99) >= 34);
  end

  always @(posedge clk_i) begin
    hit_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (hit_q.size() == 0) report("unexpected result", {found_o, hit_x_o}, 0);
      else begin
        want = hit_q.pop_front();
        if (found_o !== want.found) report("found", found_o, want.found);
        if (hit_x_o !== want.hx) report("hit_x", hit_x_o, want.hx);
        if (hit_y_o !== want.hy) report("hit_y", hit_y_o, want.hy);
      end
    end
  end

  initial begin
    #30_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    ln_ox = 0; ln_oy = 0; ln_dx = 65536; ln_dy = 0;
    poly_clear();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i])
      send_vertex(dir_rows[i].x, dir_rows[i].y, dir_rows[i].last, dir_rows[i].typed,
                  dir_rows[i].want);
    drain();

    // Zero direction: nothing can be hit.
    set_line(ONE, -ONE, 0, 0);
    send_vertex(0, -ONE, 1'b0, 1'b0, '0);
    send_vertex(ONE, ONE, 1'b1, 1'b1, '{1'b0, 0, 0});
    random_polylines(100, 1'b1);
    drain();

    set_line(CMIN, CMAX, CMAX, CMIN);
    random_polylines(150, 1'b0);
    drain();

    set_line(CMAX, CMIN, CMIN, CMAX);
    random_polylines(150, 1'b0);
    drain();

    // Receiver holds off while vertices keep coming.
    set_line(0, 0, ONE, ONE);
    calm = 1'b1;
    hold_req = 1'b1;
    random_polylines(60, 1'b1);
    drain();

    // Long stretch with no idling on either side.
    random_polylines(200, 1'b1);
    calm = 1'b0;
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      set_line($urandom_range(40 * 65536) - 20 * 65536, $urandom_range(40 * 65536) - 20 * 65536,
               (ph == 7) ? $urandom : $urandom_range(4 * 65536) - 2 * 65536,
               (ph == 7) ? $urandom : $urandom_range(4 * 65536) - 2 * 65536);
      random_polylines(120, 1'b0);
      drain();
    end

    if (err_cnt == 0 && hit_q.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/rpfh_pkg.sv
rtl/core/rpfh_div.sv
rtl/core/rpfh_ctrl.sv
rtl/core/rpfh_dp.sv
rtl/core/ray_polyline_first_hit.sv
rtl/core/rpfh_checker.sv
bench/tb_ray_polyline_first_hit.sv
